// ===== rtl/aabb_collision_resolve_core_defines.svh =====
// Assertion macros for the box collision resolver.
// Included by the RTL modules that carry concurrent checks; needs no other file.
`ifndef AABB_COLLISION_RESOLVE_CORE_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define ACR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define ACR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ACR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/acr_pkg.sv =====
// Shared constants for the box collision resolver: field widths, stream
// word layout and the width of the doubled-scale internal datapath.
`default_nettype none

package acr_pkg;

  // Default saturation width of the corrected centre.
  localparam int COORD_WIDTH_DEF = 32;

  // Field widths.
  localparam int CW_POS  = 32;
  localparam int CW_SIZE = 31;

  // Doubled-scale depths and sums stay below 2^36 in magnitude.
  localparam int DW = 38;

  // Stream word widths (input padded to whole bytes).
  localparam int IN_DATA_W  = 320;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 2;

  // Input word field offsets, lowest bit of each field.
  localparam int IN_SX_LSB = 0;
  localparam int IN_SY_LSB = 32;
  localparam int IN_SW_LSB = 64;
  localparam int IN_SH_LSB = 95;
  localparam int IN_OX_LSB = 126;
  localparam int IN_OY_LSB = 158;
  localparam int IN_OW_LSB = 190;
  localparam int IN_OH_LSB = 221;
  localparam int IN_VX_LSB = 252;
  localparam int IN_VY_LSB = 284;

  // Output flag positions in tuser.
  localparam int USER_HIT_X = 0;
  localparam int USER_HIT_Y = 1;

endpackage

`default_nettype wire

// ===== rtl/aabb_collision_resolve_core.sv =====
// An accepted input word passes stages 1 to 4 before its result word is on out_tvalid.
// Throughput: one word per cycle while the output is not stalled; each of the four stages has its own valid bit
// and a stage refills as soon as its content moves on, so a stalled output
// only holds the stages behind it. Reset (rst_n low, synchronous) clears the
// valid bits; the datapath registers are not reset and hold no state.
// Box collision resolver: four-stage pipeline of adds, compares and clamps.
// Depends on acr_pkg and aabb_collision_resolve_core_defines.svh.
`default_nettype none

`include "aabb_collision_resolve_core_defines.svh"

module aabb_collision_resolve_core #(
  parameter int COORD_WIDTH = acr_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // self_x, self_y, self_w, self_h, other_x, other_y, other_w, other_h,
  // vel_x, vel_y, then 4 zero bits
  input  wire logic [acr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // new_x, new_y, new_vel_x, new_vel_y
  output logic [acr_pkg::OUT_DATA_W-1:0]     out_tdata,
  // hit_x, hit_y
  output logic [acr_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready
);
  import acr_pkg::*;

  // Saturation is done at a width that holds both the datapath and the range.
  localparam int SW = (COORD_WIDTH + 1 > DW) ? COORD_WIDTH + 1 : DW;
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO =
    {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  // Input word unpacking.
  logic signed [CW_POS-1:0] f_sx, f_sy, f_ox, f_oy, f_vx, f_vy;
  logic [CW_SIZE-1:0]       f_sw, f_sh, f_ow, f_oh;

  assign f_sx = in_tdata[IN_SX_LSB +: CW_POS];
  assign f_sy = in_tdata[IN_SY_LSB +: CW_POS];
  assign f_sw = in_tdata[IN_SW_LSB +: CW_SIZE];
  assign f_sh = in_tdata[IN_SH_LSB +: CW_SIZE];
  assign f_ox = in_tdata[IN_OX_LSB +: CW_POS];
  assign f_oy = in_tdata[IN_OY_LSB +: CW_POS];
  assign f_ow = in_tdata[IN_OW_LSB +: CW_SIZE];
  assign f_oh = in_tdata[IN_OH_LSB +: CW_SIZE];
  assign f_vx = in_tdata[IN_VX_LSB +: CW_POS];
  assign f_vy = in_tdata[IN_VY_LSB +: CW_POS];

  // Stage valid bits and the ready chain from the output backward.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: doubled edge-to-edge depths and centre side compares.
  // ---------------------------------------------------------------
  logic signed [DW-1:0] sx_e, sy_e, ox_e, oy_e, sw_e, sh_e, ow_e, oh_e;
  logic signed [DW-1:0] dt_nxt, db_nxt, dl_nxt, dr_nxt;
  logic signed [DW-1:0] dt_r, db_r, dl_r, dr_r;
  logic                 ylt_r, ygt_r, xlt_r, xgt_r;
  logic signed [CW_POS-1:0] sx1_r, sy1_r, vx1_r, vy1_r;

  assign sx_e = DW'(f_sx);
  assign sy_e = DW'(f_sy);
  assign ox_e = DW'(f_ox);
  assign oy_e = DW'(f_oy);
  assign sw_e = {{(DW-CW_SIZE){1'b0}}, f_sw};
  assign sh_e = {{(DW-CW_SIZE){1'b0}}, f_sh};
  assign ow_e = {{(DW-CW_SIZE){1'b0}}, f_ow};
  assign oh_e = {{(DW-CW_SIZE){1'b0}}, f_oh};

  always_comb begin
    dt_nxt = ((sy_e <<< 1) + sh_e) - ((oy_e <<< 1) - oh_e);
    db_nxt = ((oy_e <<< 1) + oh_e) - ((sy_e <<< 1) - sh_e);
    dl_nxt = ((ox_e <<< 1) + ow_e) - ((sx_e <<< 1) - sw_e);
    dr_nxt = ((sx_e <<< 1) + sw_e) - ((ox_e <<< 1) - ow_e);
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      dt_r  <= dt_nxt;
      db_r  <= db_nxt;
      dl_r  <= dl_nxt;
      dr_r  <= dr_nxt;
      ylt_r <= f_sy < f_oy;
      ygt_r <= f_sy > f_oy;
      xlt_r <= f_sx < f_ox;
      xgt_r <= f_sx > f_ox;
      sx1_r <= f_sx;
      sy1_r <= f_sy;
      vx1_r <= f_vx;
      vy1_r <= f_vy;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: orient each depth by the centre side and clip at zero.
  // ---------------------------------------------------------------
  logic signed [DW-1:0] top_o, bot_o, lft_o, rgt_o;
  logic signed [DW-1:0] top_nxt, bot_nxt, lft_nxt, rgt_nxt;
  logic signed [DW-1:0] top_r, bot_r, lft_r, rgt_r;
  logic signed [CW_POS-1:0] sx2_r, sy2_r, vx2_r, vy2_r;

  always_comb begin
    top_o   = ylt_r ? dt_r : -dt_r;
    bot_o   = ygt_r ? db_r : -db_r;
    lft_o   = xgt_r ? dl_r : -dl_r;
    rgt_o   = xlt_r ? dr_r : -dr_r;
    top_nxt = top_o[DW-1] ? '0 : top_o;
    bot_nxt = bot_o[DW-1] ? '0 : bot_o;
    lft_nxt = lft_o[DW-1] ? '0 : lft_o;
    rgt_nxt = rgt_o[DW-1] ? '0 : rgt_o;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      lft_r <= lft_nxt;
      rgt_r <= rgt_nxt;
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      vx2_r <= vx1_r;
      vy2_r <= vy1_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: axis totals, axis choice and doubled corrected centres.
  // ---------------------------------------------------------------
  logic signed [DW-1:0] ex, ey;
  logic                 hx_nxt, hy_nxt;
  logic signed [DW-1:0] px_nxt, py_nxt;
  logic                 hx3_r, hy3_r;
  logic signed [DW-1:0] px3_r, py3_r;
  logic                 lpos_r, rpos_r, tpos_r, bpos_r;
  logic signed [CW_POS-1:0] sx3_r, sy3_r, vx3_r, vy3_r;

  always_comb begin
    ex     = lft_r + rgt_r;
    ey     = top_r + bot_r;
    hx_nxt = (ex != '0) && (ex <= ey);
    hy_nxt = (ey != '0) && (ey <= ex);
    px_nxt = (DW'(sx2_r) <<< 1) + lft_r - rgt_r;
    py_nxt = (DW'(sy2_r) <<< 1) + bot_r - top_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      hx3_r  <= hx_nxt;
      hy3_r  <= hy_nxt;
      px3_r  <= px_nxt;
      py3_r  <= py_nxt;
      lpos_r <= lft_r != '0;
      rpos_r <= rgt_r != '0;
      tpos_r <= top_r != '0;
      bpos_r <= bot_r != '0;
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
      vx3_r  <= vx2_r;
      vy3_r  <= vy2_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: halve (floor), saturate, clamp velocity into the output word.
  // ---------------------------------------------------------------
  logic signed [DW-1:0]     px_half, py_half;
  logic signed [SW-1:0]     px_w, py_w, px_sat, py_sat;
  logic signed [CW_POS-1:0] nx_nxt, ny_nxt, nvx_nxt, nvy_nxt;
  logic signed [CW_POS-1:0] nx_r, ny_r, nvx_r, nvy_r;
  logic                     hx4_r, hy4_r;

  always_comb begin
    px_half = px3_r >>> 1;
    py_half = py3_r >>> 1;
    px_w    = hx3_r ? SW'(px_half) : SW'(sx3_r);
    py_w    = hy3_r ? SW'(py_half) : SW'(sy3_r);

    priority if (px_w > SAT_HI) px_sat = SAT_HI;
    else if (px_w < SAT_LO)     px_sat = SAT_LO;
    else                        px_sat = px_w;

    priority if (py_w > SAT_HI) py_sat = SAT_HI;
    else if (py_w < SAT_LO)     py_sat = SAT_LO;
    else                        py_sat = py_w;

    nx_nxt = px_sat[CW_POS-1:0];
    ny_nxt = py_sat[CW_POS-1:0];

    // Drop the velocity component that points into the obstacle.
    nvx_nxt = vx3_r;
    if (hx3_r && ((lpos_r && vx3_r < 0) || (rpos_r && vx3_r > 0))) begin
      nvx_nxt = '0;
    end
    nvy_nxt = vy3_r;
    if (hy3_r && ((tpos_r && vy3_r > 0) || (bpos_r && vy3_r < 0))) begin
      nvy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      nx_r  <= nx_nxt;
      ny_r  <= ny_nxt;
      nvx_r <= nvx_nxt;
      nvy_r <= nvy_nxt;
      hx4_r <= hx3_r;
      hy4_r <= hy3_r;
    end
  end

  assign out_tvalid             = v4_r;
  assign out_tdata              = {nvy_r, nvx_r, ny_r, nx_r};
  assign out_tuser[USER_HIT_X]  = hx4_r;
  assign out_tuser[USER_HIT_Y]  = hy4_r;

  // ---------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------
  // The centres sit on one side only, so top and bottom never both push.
  `ACR_ASSERT_IMPL(a_tb_exclusive, clk, rst_n, v2_r, !(top_r != '0 && bot_r != '0),
    "top and bottom depths both nonzero")
  // A resolved x axis has a nonzero push on at least one side.
  `ACR_ASSERT_IMPL(a_hx_has_depth, clk, rst_n, v3_r && hx3_r, lpos_r || rpos_r,
    "x resolved without any x depth")
  // A stalled stage-3 word keeps its axis choice.
  `ACR_ASSERT_NEXT(a_s3_hold, clk, rst_n, v3_r && !rdy4,
    v3_r && $stable(hx3_r) && $stable(hy3_r) && $stable(px3_r),
    "stage 3 content changed under stall")
  // An empty output stage lets the whole pipe take a word.
  `ACR_ASSERT_IMPL(a_empty_ready, clk, rst_n, !out_tvalid, in_tready,
    "input stalled with empty output stage")

endmodule

`default_nettype wire
